/* src/tks_pkg.sv */
// tks_pkg: shared types and defaults for the top-k sorted table
// request codes, sequencer states and default sizes
// no dependencies
package tks_pkg;

    // default sizes
    localparam int TKS_ENTRIES   = 16;
    localparam int TKS_TAG_CHARS = 8;

    // fixed field widths
    localparam int REQ_W   = 2;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 64;
    localparam int RIDX_W  = 4;
    localparam int PLACE_W = 4;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_READ   = 2'd2
    } t_req;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST_CMP,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_READ_WAIT,
        ST_FIN
    } t_state;

endpackage

/* src/top_k_sorted_table_top.sv */
// top_k_sorted_table_top: top-k list of (score, tag) pairs in descending score order
// one table memory, one shared score comparator, a small sequencer
// depends on tks_pkg
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  request  | in        | i_valid / o_ready  | i_req_type i_score i_name_tag i_read_index
//  result   | out       | o_valid / i_ready  | o_qualifies o_place_index o_bad_request
//           |           |                    | o_entry_valid o_entry_score o_entry_tag
//
// one request at a time; o_ready is high only while the sequencer is idle
// insert walks up from the bottom of the table through the single memory port,
// reading the entry above the hole, then moving it down or dropping the new pair in
// a query or insert on a full table first compares against the last entry
// the result sits in an output register; a stalled result holds the sequencer
// in its final step, the next request is taken as soon as the result moves on
// reset empties the table at once through the fill count, no clearing pass
module top_k_sorted_table_top #(
    parameter int ENTRIES   = tks_pkg::TKS_ENTRIES,
    parameter int TAG_CHARS = tks_pkg::TKS_TAG_CHARS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tks_pkg::REQ_W-1:0]    i_req_type,
    input  logic [tks_pkg::SCORE_W-1:0]  i_score,
    input  logic [tks_pkg::TAG_W-1:0]    i_name_tag,
    input  logic [tks_pkg::RIDX_W-1:0]   i_read_index,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_qualifies,
    output logic [tks_pkg::PLACE_W-1:0]  o_place_index,
    output logic                         o_bad_request,
    output logic                         o_entry_valid,
    output logic [tks_pkg::SCORE_W-1:0]  o_entry_score,
    output logic [tks_pkg::TAG_W-1:0]    o_entry_tag
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int TW = 8 * TAG_CHARS;
    localparam int SW = tks_pkg::SCORE_W;
    localparam int MW = SW + TW;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    // sequencer and work registers
    tks_pkg::t_state r_state, n_state;
    tks_pkg::t_req   r_req, n_req;
    logic [SW-1:0]   r_score, n_score;
    logic [TW-1:0]   r_tag, n_tag;
    logic            r_ridx_ok, n_ridx_ok;
    logic [AW-1:0]   r_hole, n_hole;
    logic [CW-1:0]   r_count, n_count;

    // staged result
    logic            r_res_q, n_res_q;
    logic [tks_pkg::PLACE_W-1:0] r_res_place, n_res_place;
    logic            r_res_bad, n_res_bad;
    logic            r_res_ev, n_res_ev;
    logic [SW-1:0]   r_res_es, n_res_es;
    logic [TW-1:0]   r_res_et, n_res_et;

    // output register
    logic            r_o_valid;
    logic            r_o_q;
    logic [tks_pkg::PLACE_W-1:0] r_o_place;
    logic            r_o_bad;
    logic            r_o_ev;
    logic [SW-1:0]   r_o_es;
    logic [TW-1:0]   r_o_et;

    // table memory
    logic [MW-1:0]   r_mem [ENTRIES];
    logic [MW-1:0]   r_rd_data;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [MW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;

    logic [SW-1:0]   rd_score;
    logic [TW-1:0]   rd_tag;
    logic            beats;
    logic            out_free;

    assign rd_score = r_rd_data[MW-1:TW];
    assign rd_tag   = r_rd_data[TW-1:0];
    // the shared comparator
    assign beats    = r_score > rd_score;
    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == tks_pkg::ST_IDLE);

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[mem_raddr];
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tks_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // work and staging registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_score     <= n_score;
        r_tag       <= n_tag;
        r_ridx_ok   <= n_ridx_ok;
        r_hole      <= n_hole;
        r_res_q     <= n_res_q;
        r_res_place <= n_res_place;
        r_res_bad   <= n_res_bad;
        r_res_ev    <= n_res_ev;
        r_res_es    <= n_res_es;
        r_res_et    <= n_res_et;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_score     = r_score;
        n_tag       = r_tag;
        n_ridx_ok   = r_ridx_ok;
        n_hole      = r_hole;
        n_count     = r_count;
        n_res_q     = r_res_q;
        n_res_place = r_res_place;
        n_res_bad   = r_res_bad;
        n_res_ev    = r_res_ev;
        n_res_es    = r_res_es;
        n_res_et    = r_res_et;
        mem_we      = 1'b0;
        mem_waddr   = r_hole;
        mem_wdata   = {r_score, r_tag};
        mem_raddr   = LAST;

        unique case (r_state)
            tks_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_req       = tks_pkg::t_req'(i_req_type);
                    n_score     = i_score;
                    n_tag       = i_name_tag[TW-1:0];
                    n_ridx_ok   = (32'(i_read_index) < 32'(ENTRIES)) &&
                                  (32'(i_read_index) < 32'(r_count));
                    n_res_q     = 1'b0;
                    n_res_place = '0;
                    n_res_bad   = 1'b0;
                    n_res_ev    = 1'b0;
                    n_res_es    = '0;
                    n_res_et    = '0;
                    unique case (i_req_type)
                        tks_pkg::REQ_INSERT: begin
                            if (i_name_tag[TW-1:0] == '0) begin
                                n_res_bad = 1'b1;
                                n_state   = tks_pkg::ST_FIN;
                            end else if (r_count == FULL) begin
                                mem_raddr = LAST;
                                n_state   = tks_pkg::ST_LAST_CMP;
                            end else begin
                                n_hole  = AW'(r_count);
                                n_state = tks_pkg::ST_WALK_RD;
                            end
                        end
                        tks_pkg::REQ_QUERY: begin
                            if (r_count == FULL) begin
                                mem_raddr = LAST;
                                n_state   = tks_pkg::ST_LAST_CMP;
                            end else begin
                                n_res_q = 1'b1;
                                n_state = tks_pkg::ST_FIN;
                            end
                        end
                        tks_pkg::REQ_READ: begin
                            mem_raddr = AW'(i_read_index);
                            n_state   = tks_pkg::ST_READ_WAIT;
                        end
                        default: begin
                            n_state = tks_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            // compare against the last entry of a full table
            tks_pkg::ST_LAST_CMP: begin
                if (r_req == tks_pkg::REQ_QUERY) begin
                    n_res_q = beats;
                    n_state = tks_pkg::ST_FIN;
                end else if (beats) begin
                    n_hole  = LAST;
                    n_state = tks_pkg::ST_WALK_RD;
                end else begin
                    n_state = tks_pkg::ST_FIN;
                end
            end
            // read the entry above the hole, or land at the top
            tks_pkg::ST_WALK_RD: begin
                if (r_hole == '0) begin
                    mem_we      = 1'b1;
                    mem_waddr   = '0;
                    n_res_q     = 1'b1;
                    n_res_place = '0;
                    if (r_count != FULL) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = tks_pkg::ST_FIN;
                end else begin
                    mem_raddr = r_hole - 1'b1;
                    n_state   = tks_pkg::ST_WALK_CMP;
                end
            end
            // move the entry down or drop the new pair into the hole
            tks_pkg::ST_WALK_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_hole;
                if (beats) begin
                    mem_wdata = r_rd_data;
                    n_hole    = r_hole - 1'b1;
                    n_state   = tks_pkg::ST_WALK_RD;
                end else begin
                    mem_wdata   = {r_score, r_tag};
                    n_res_q     = 1'b1;
                    n_res_place = tks_pkg::PLACE_W'(r_hole);
                    if (r_count != FULL) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = tks_pkg::ST_FIN;
                end
            end
            // read data is back
            tks_pkg::ST_READ_WAIT: begin
                n_res_ev = r_ridx_ok;
                n_res_es = r_ridx_ok ? rd_score : '0;
                n_res_et = r_ridx_ok ? rd_tag : '0;
                n_state  = tks_pkg::ST_FIN;
            end
            // hand the result to the output register
            tks_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = tks_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tks_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == tks_pkg::ST_FIN && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == tks_pkg::ST_FIN && out_free) begin
            r_o_q     <= r_res_q;
            r_o_place <= r_res_place;
            r_o_bad   <= r_res_bad;
            r_o_ev    <= r_res_ev;
            r_o_es    <= r_res_es;
            r_o_et    <= r_res_et;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_qualifies   = r_o_q;
    assign o_place_index = r_o_place;
    assign o_bad_request = r_o_bad;
    assign o_entry_valid = r_o_ev;
    assign o_entry_score = r_o_es;
    assign o_entry_tag   = tks_pkg::TAG_W'(r_o_et);

endmodule
